>>> rtl/core/vctr_pkg.sv
// Shared types, constants and ROM tables of the counter-to-resistance converter.
package vctr_pkg;

    localparam int ROM_SLOTS         = 64;
    localparam int ROM_IDX_W         = 6;
    localparam int TABLE_ENTRIES_DEF = 25;
    localparam int SRCH_W            = ROM_IDX_W + 2;

    localparam int CNT_W    = 32;
    localparam int FREQ_W   = 32;
    localparam int VOLT_W   = 20;
    localparam int CUR_W    = 14;
    localparam int SUP_W    = 20;
    localparam int FOFF_W   = 10;
    localparam int VOFF_W   = 17;
    localparam int RATE_W   = 10;
    localparam int RES_W    = 20;
    localparam int FAULT_W  = 2;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 20;
    localparam int IN_DW    = 32;
    localparam int OUT_DW   = 80;

    localparam int DIV_NUM_W = FREQ_W + VOLT_W;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [CUR_W-1:0]  CUR_RST  = CUR_W'(160);
    localparam logic [SUP_W-1:0]  SUP_RST  = SUP_W'(800000);
    localparam logic [FOFF_W-1:0] FOFF_RST = FOFF_W'(20);
    localparam logic [VOFF_W-1:0] VOFF_RST = VOFF_W'(5700);
    localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(1);

    typedef enum logic [CFG_AW-1:0] {
        CFG_CURRENT  = 3'd0,
        CFG_SUPPLY   = 3'd1,
        CFG_FREQ_OFF = 3'd2,
        CFG_VOLT_OFF = 3'd3,
        CFG_RATE     = 3'd4
    } t_cfg_idx;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_ZERO_CUR = 2'd1,
        FAULT_SUPPLY   = 2'd2
    } t_fault;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_FREQ,
        S_RANGE,
        S_SEARCH,
        S_FETCH,
        S_MUL,
        S_DIVA_GO,
        S_DIVA_WAIT,
        S_VIN,
        S_DIVB_GO,
        S_DIVB_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [FREQ_W-1:0] rom_freq(input logic [ROM_IDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        case (idx)
            6'd0:  f = 32'd26130;
            6'd1:  f = 32'd31330;
            6'd2:  f = 32'd37320;
            6'd3:  f = 32'd45270;
            6'd4:  f = 32'd55150;
            6'd5:  f = 32'd67270;
            6'd6:  f = 32'd82680;
            6'd7:  f = 32'd99870;
            6'd8:  f = 32'd121190;
            6'd9:  f = 32'd146020;
            6'd10: f = 32'd175270;
            6'd11: f = 32'd208990;
            6'd12: f = 32'd247770;
            6'd13: f = 32'd291780;
            6'd14: f = 32'd341260;
            6'd15: f = 32'd396650;
            6'd16: f = 32'd457900;
            6'd17: f = 32'd525140;
            6'd18: f = 32'd598560;
            6'd19: f = 32'd677660;
            6'd20: f = 32'd762750;
            6'd21: f = 32'd853760;
            6'd22: f = 32'd950200;
            6'd23: f = 32'd1051710;
            6'd24: f = 32'd1158000;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [VOLT_W-1:0] rom_volt(input logic [ROM_IDX_W-1:0] idx);
        logic [VOLT_W-1:0] v;
        if (idx < ROM_IDX_W'(25)) begin
            v = VOLT_W'(340000) + VOLT_W'({idx, 14'd0}) + VOLT_W'({idx, 11'd0})
                + VOLT_W'({idx, 10'd0}) + VOLT_W'({idx, 9'd0}) + VOLT_W'({idx, 5'd0});
        end else begin
            v = '0;
        end
        return v;
    endfunction

endpackage

>>> rtl/core/vco_count_to_resistance.sv
// Top level: oscillator count to frequency, voltage and resistance.
// From accept to output beat: a rejected sample goes straight to the output; a clamped
// one adds the resistance division unless a fault is flagged; an interpolated one adds
// the binary search and the shared serial divider for interpolation and resistance.
// Throughput: one beat in flight; next beat taken the cycle after its result is registered.
// Reset: synchronous active low; clears control, state valid bit and config to defaults.
module vco_count_to_resistance #(
    parameter int TABLE_ENTRIES = vctr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [31:0] coarse_count
    input  logic [vctr_pkg::IN_DW-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] accepted, [32:1] freq_hz, [52:33] vin_uv, [72:53] res_kohm,
    // [74:73] fault, [79:75] zero
    output logic [vctr_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [vctr_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [vctr_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import vctr_pkg::*;

    localparam logic [ROM_IDX_W-1:0] LAST_IDX = ROM_IDX_W'(TABLE_ENTRIES - 1);
    localparam logic signed [SRCH_W-1:0] HI_MAX = SRCH_W'(TABLE_ENTRIES - 2);

    // config
    logic [CUR_W-1:0]  r_current;
    logic [SUP_W-1:0]  r_supply;
    logic [FOFF_W-1:0] r_freq_off;
    logic [VOFF_W-1:0] r_volt_off;
    logic [RATE_W-1:0] r_rate;

    // state memory: {prev_diff, prev_count}
    logic [2*CNT_W-1:0] r_mem [1];
    logic [2*CNT_W-1:0] r_mem_q;
    logic               r_mem_vld;
    logic               mem_re;
    logic               mem_we;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_diff;
    logic              r_ok;
    logic [FREQ_W-1:0] r_freq;
    logic signed [SRCH_W-1:0] r_lo, r_hi;
    logic [VOLT_W-1:0] r_v0;
    logic [FREQ_W-1:0] r_fdiff;
    logic [VOLT_W-1:0] r_vdiff;
    logic [FREQ_W-1:0] r_den;
    logic              r_interp;
    logic [DIV_NUM_W-1:0] r_prod;
    logic [VOLT_W-1:0] r_dv;
    logic [VOLT_W+1:0] r_vin;
    logic [RES_W-1:0]  r_res;
    t_fault            r_fault;

    logic              r_out_vld;
    logic [OUT_DW-1:0] r_out_data;

    // datapath helpers
    logic [CNT_W-1:0]  prev_count, prev_diff, diff;
    logic [CNT_W:0]    d2;
    logic [CNT_W+1:0]  last3;
    logic              win_ok;
    logic [CNT_W+RATE_W:0] freq_full;
    logic signed [SRCH_W-1:0] mid;
    logic [ROM_IDX_W-1:0] mid_idx, hic, hic1;
    logic              srch_go;
    logic [FREQ_W-1:0] f0, f1;
    logic [VOLT_W-1:0] v0, v1;
    logic [VOLT_W+1:0] vin_sum;
    logic [SUP_W-1:0]  res_num;
    logic              out_free;

    t_div_req             div_req;
    t_div_sts             div_sts;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quot;

    vctr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current  <= CUR_RST;
            r_supply   <= SUP_RST;
            r_freq_off <= FOFF_RST;
            r_volt_off <= VOFF_RST;
            r_rate     <= RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CURRENT:  r_current  <= i_cfg_wdata[CUR_W-1:0];
                CFG_SUPPLY:   r_supply   <= i_cfg_wdata[SUP_W-1:0];
                CFG_FREQ_OFF: r_freq_off <= i_cfg_wdata[FOFF_W-1:0];
                CFG_VOLT_OFF: r_volt_off <= i_cfg_wdata[VOFF_W-1:0];
                CFG_RATE:     r_rate     <= i_cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prev_count = r_mem_vld ? r_mem_q[CNT_W-1:0] : '0;
        prev_diff  = r_mem_vld ? r_mem_q[2*CNT_W-1:CNT_W] : '0;
        diff       = r_count - prev_count;
        d2         = {diff, 1'b0};
        last3      = {2'b0, prev_diff} + {1'b0, prev_diff, 1'b0};
        win_ok     = ({1'b0, d2} < last3) && (d2 > {1'b0, prev_diff});

        freq_full  = (CNT_W+RATE_W+1)'(r_diff) * r_rate + (CNT_W+RATE_W+1)'(r_freq_off);

        mid        = r_lo + ((r_hi - r_lo) >>> 1);
        mid_idx    = mid[ROM_IDX_W-1:0];
        srch_go    = (r_lo <= r_hi);

        if (r_hi < 0) begin
            hic = '0;
        end else if (r_hi > HI_MAX) begin
            hic = HI_MAX[ROM_IDX_W-1:0];
        end else begin
            hic = r_hi[ROM_IDX_W-1:0];
        end
        hic1 = hic + ROM_IDX_W'(1);
        f0   = rom_freq(hic);
        f1   = rom_freq(hic1);
        v0   = rom_volt(hic);
        v1   = rom_volt(hic1);

        vin_sum = {2'b0, r_v0} + {2'b0, r_dv} + (VOLT_W+2)'(r_volt_off);
        res_num = r_supply - r_vin[SUP_W-1:0];
        out_free = !r_out_vld || i_m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_q <= r_mem[0];
        end
        if (mem_we) begin
            r_mem[0] <= {diff, r_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mem_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_mem_vld <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        div_req.start = 1'b0;
        div_req.nbits = DIV_CNT_W'(DIV_NUM_W);
        div_num       = r_prod;
        div_den       = r_den;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    mem_re  = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                mem_we  = 1'b1;
                n_state = S_FREQ;
            end
            S_FREQ:   n_state = r_ok ? S_RANGE : S_DONE;
            S_RANGE: begin
                if (r_freq <= rom_freq('0) || r_freq >= rom_freq(LAST_IDX)) begin
                    n_state = S_VIN;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: n_state = srch_go ? S_SEARCH : S_FETCH;
            S_FETCH:  n_state = S_MUL;
            S_MUL:    n_state = r_interp ? S_DIVA_GO : S_VIN;
            S_DIVA_GO: begin
                div_req.start = 1'b1;
                n_state       = S_DIVA_WAIT;
            end
            S_DIVA_WAIT: if (div_sts.done) n_state = S_VIN;
            S_VIN: begin
                if (r_current == '0 || vin_sum >= {2'b0, r_supply}) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIVB_GO;
                end
            end
            S_DIVB_GO: begin
                div_req.start = 1'b1;
                div_req.nbits = DIV_CNT_W'(SUP_W);
                div_num       = {res_num, (DIV_NUM_W-SUP_W)'(0)};
                div_den       = DIV_DEN_W'(r_current);
                n_state       = S_DIVB_WAIT;
            end
            S_DIVB_WAIT: if (div_sts.done) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_count <= i_s_axis_tdata;
            end
            S_LOAD: begin
                r_diff <= diff;
                r_ok   <= win_ok;
            end
            S_FREQ: begin
                r_res   <= '0;
                r_fault <= FAULT_NONE;
                r_dv    <= '0;
                if (!r_ok) begin
                    r_freq <= '0;
                    r_vin  <= '0;
                end else if (freq_full[CNT_W+RATE_W:FREQ_W] != '0) begin
                    r_freq <= '1;
                end else begin
                    r_freq <= freq_full[FREQ_W-1:0];
                end
            end
            S_RANGE: begin
                r_lo <= '0;
                r_hi <= SRCH_W'(LAST_IDX);
                if (r_freq <= rom_freq('0)) begin
                    r_v0 <= rom_volt('0);
                end else begin
                    r_v0 <= rom_volt(LAST_IDX);
                end
            end
            S_SEARCH: begin
                if (srch_go) begin
                    if (rom_freq(mid_idx) < r_freq) begin
                        r_lo <= mid + SRCH_W'(1);
                    end else begin
                        r_hi <= mid - SRCH_W'(1);
                    end
                end
            end
            S_FETCH: begin
                r_v0     <= v0;
                r_fdiff  <= r_freq - f0;
                r_vdiff  <= v1 - v0;
                r_den    <= f1 - f0;
                r_interp <= (f1 > f0) && (v1 > v0) && (r_freq > f0);
            end
            S_MUL: begin
                r_prod <= r_fdiff * r_vdiff;
            end
            S_DIVA_WAIT: begin
                if (div_sts.done) begin
                    r_dv <= div_quot[VOLT_W-1:0];
                end
            end
            S_VIN: begin
                r_vin <= vin_sum;
                if (r_current == '0) begin
                    r_fault <= FAULT_ZERO_CUR;
                end else if (vin_sum >= {2'b0, r_supply}) begin
                    r_fault <= FAULT_SUPPLY;
                end
            end
            S_DIVB_WAIT: begin
                if (div_sts.done) begin
                    r_res <= div_quot[RES_W-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_data <= {5'd0, r_fault, r_res, r_vin[VOLT_W-1:0], r_freq, r_ok};
                end
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("output loaded outside done state");

    a_fault_res_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_data[74:73] != FAULT_NONE |-> r_out_data[72:53] == '0)
        else $error("nonzero resistance with fault");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_data[0] |-> r_out_data[74:1] == '0)
        else $error("rejected beat carries nonzero fields");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !mem_re)
        else $error("state read while busy");

endmodule

>>> rtl/core/vctr_div.sv
// Shared bit-serial restoring divider, one quotient bit per cycle.
module vctr_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vctr_pkg::t_div_req               i_req,
    input  logic [vctr_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [vctr_pkg::DIV_DEN_W-1:0]   i_den,
    output vctr_pkg::t_div_sts               o_sts,
    output logic [vctr_pkg::DIV_NUM_W-1:0]   o_quot
);
    import vctr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;
    logic [DIV_DEN_W:0]   trial_sub;

    always_comb begin
        trial     = {r_rem, r_q[DIV_NUM_W-1]};
        qbit      = (trial >= {1'b0, r_den});
        trial_sub = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= qbit ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            r_q   <= {r_q[DIV_NUM_W-2:0], qbit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule
